// File: rtl/mcr_pkg.sv
// shared constants, types and helpers for the midpoint circle rasteriser
`timescale 1ns / 1ps

package mcr_pkg;

    localparam int COORD_BITS = 11;
    // radius of the largest circle: sqrt(2) times the coordinate range, one bit more
    localparam int R_W    = COORD_BITS + 1;
    // radicand padded to an even width for the two-bits-per-step root
    localparam int RAD_W  = 2 * R_W;
    localparam int SQ_W   = 2 * COORD_BITS + 1;
    localparam int D_W    = R_W + 3;
    localparam int PIX_W  = 14;
    localparam int ITER_W = $clog2(R_W);
    localparam int IDX_W  = 3;

    localparam logic [IDX_W-1:0] LAST_START_PIX = IDX_W'(3);
    localparam logic [IDX_W-1:0] LAST_STEP_PIX  = IDX_W'(7);

    localparam logic CMD_START = 1'b0;
    localparam logic CMD_STEP  = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SQ_X,
        ST_SQ_Y,
        ST_ROOT,
        ST_LOAD,
        ST_STEP,
        ST_EMIT
    } mcr_state_t;

    typedef struct packed {
        logic             capture;
        logic             sq_first;
        logic             sq_second;
        logic             root_iter;
        logic             load_circle;
        logic             step;
        logic             emit;
        logic             emit_start;
        logic [IDX_W-1:0] emit_idx;
        logic             emit_last;
    } mcr_ctl_t;

    typedef struct packed {
        logic active;
        logic out_free;
    } mcr_status_t;

    // centre plus or minus offset, wrapped to the pixel width
    function automatic logic [PIX_W-1:0] pix_sum(input logic [31:0] base,
                                                 input logic [31:0] off,
                                                 input logic        neg);
        logic [31:0] s;
        s = neg ? (base - off) : (base + off);
        return s[PIX_W-1:0];
    endfunction

endpackage

// File: rtl/mcr_ctrl.sv
// controller state machine for the midpoint circle rasteriser
`timescale 1ns / 1ps

module mcr_ctrl
    import mcr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        cmd,
    input  mcr_status_t status,
    output mcr_ctl_t    ctl
);

    mcr_state_t        state_reg, state_next;
    logic [ITER_W-1:0] iter_reg, iter_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic              start_mode_reg, start_mode_next;
    logic              last_pix;

    assign last_pix = (idx_reg == (start_mode_reg ? LAST_START_PIX : LAST_STEP_PIX));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            iter_reg       <= '0;
            idx_reg        <= '0;
            start_mode_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            iter_reg       <= iter_next;
            idx_reg        <= idx_next;
            start_mode_reg <= start_mode_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (cmd == CMD_START)
                        state_next = ST_SQ_X;
                    else if (status.active)
                        state_next = ST_STEP;
                end
            end
            ST_SQ_X: state_next = ST_SQ_Y;
            ST_SQ_Y: state_next = ST_ROOT;
            ST_ROOT:
            begin
                if (iter_reg == '0)
                    state_next = ST_LOAD;
            end
            ST_LOAD: state_next = ST_EMIT;
            ST_STEP: state_next = ST_EMIT;
            ST_EMIT:
            begin
                if (status.out_free && last_pix)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // counters
    always_comb
    begin
        iter_next       = iter_reg;
        idx_next        = idx_reg;
        start_mode_next = start_mode_reg;
        case (state_reg)
            ST_SQ_Y: iter_next = ITER_W'(R_W - 1);
            ST_ROOT: iter_next = iter_reg - ITER_W'(1);
            ST_LOAD:
            begin
                idx_next        = '0;
                start_mode_next = 1'b1;
            end
            ST_STEP:
            begin
                idx_next        = '0;
                start_mode_next = 1'b0;
            end
            ST_EMIT:
            begin
                if (status.out_free)
                    idx_next = idx_reg + IDX_W'(1);
            end
            default: ;
        endcase
    end

    // datapath commands
    always_comb
    begin
        in_ready        = 1'b0;
        ctl             = '0;
        ctl.emit_start  = start_mode_reg;
        ctl.emit_idx    = idx_reg;
        ctl.emit_last   = last_pix;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready    = 1'b1;
                ctl.capture = in_valid && (cmd == CMD_START);
            end
            ST_SQ_X: ctl.sq_first    = 1'b1;
            ST_SQ_Y: ctl.sq_second   = 1'b1;
            ST_ROOT: ctl.root_iter   = 1'b1;
            ST_LOAD: ctl.load_circle = 1'b1;
            ST_STEP: ctl.step        = 1'b1;
            ST_EMIT: ctl.emit        = status.out_free;
            default: ;
        endcase
    end

endmodule

// File: rtl/mcr_datapath.sv
// datapath: radius root, midpoint decision update and pixel output register
`timescale 1ns / 1ps

module mcr_datapath
    import mcr_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  mcr_ctl_t                ctl,
    output mcr_status_t             status,
    input  logic [COORD_BITS-1:0]   center_x,
    input  logic [COORD_BITS-1:0]   center_y,
    input  logic [COORD_BITS-1:0]   edge_x,
    input  logic [COORD_BITS-1:0]   edge_y,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic signed [PIX_W-1:0] pixel_x,
    output logic signed [PIX_W-1:0] pixel_y,
    output logic                    run_end,
    output logic                    done_res
);

    logic [COORD_BITS-1:0]   mid_x_reg, mid_y_reg;
    logic [COORD_BITS-1:0]   dx_reg, dy_reg;
    logic [2*COORD_BITS-1:0] sq_reg;
    logic [RAD_W-1:0]        rad_reg;
    logic [R_W+1:0]          rem_reg;
    logic [R_W-1:0]          root_reg;
    logic [R_W-1:0]          offset_a_reg, offset_b_reg;
    logic signed [D_W-1:0]   decision_reg, step_a_reg, step_b_reg;
    logic                    active_reg, active_next;
    logic                    out_valid_reg;
    logic [PIX_W-1:0]        pixel_x_reg, pixel_y_reg;
    logic                    run_end_reg, done_res_reg;

    logic [COORD_BITS-1:0]   abs_dx, abs_dy, mul_in;
    logic [2*COORD_BITS-1:0] prod;
    logic [SQ_W-1:0]         dist_sq;
    logic [R_W+3:0]          rem_sh, trial, rem_diff;
    logic                    fits;

    logic                    go_down;
    logic [R_W-1:0]          offset_a_next, offset_b_next;
    logic signed [D_W-1:0]   step_a_next, step_b_next, decision_next;

    logic [IDX_W-1:0]        k;
    logic [R_W-1:0]          off_x, off_y;

    assign abs_dx = (center_x >= edge_x) ? (center_x - edge_x) : (edge_x - center_x);
    assign abs_dy = (center_y >= edge_y) ? (center_y - edge_y) : (edge_y - center_y);

    // one shared squarer, x first then y
    assign mul_in  = ctl.sq_first ? dx_reg : dy_reg;
    assign prod    = mul_in * mul_in;
    assign dist_sq = {1'b0, sq_reg} + {1'b0, prod};

    // restoring square root, two radicand bits a cycle
    assign rem_sh   = {rem_reg, rad_reg[RAD_W-1 -: 2]};
    assign trial    = {2'b00, root_reg, 2'b01};
    assign fits     = (rem_sh >= trial);
    assign rem_diff = rem_sh - trial;

    // midpoint step
    assign go_down       = !decision_reg[D_W-1];
    assign offset_a_next = offset_a_reg + R_W'(1);
    assign offset_b_next = go_down ? (offset_b_reg - R_W'(1)) : offset_b_reg;
    assign step_a_next   = step_a_reg + D_W'(2);
    assign step_b_next   = go_down ? (step_b_reg + D_W'(2)) : step_b_reg;
    assign decision_next = decision_reg + (go_down ? step_b_next : D_W'(0))
                           + step_a_next + D_W'(1);

    always_comb
    begin
        active_next = active_reg;
        if (ctl.load_circle)
            active_next = (root_reg != '0);
        else if (ctl.step)
            active_next = (offset_a_next < offset_b_next);
    end

    // start pixels are the four axis points of the eight-way pattern
    assign k = ctl.emit_start
             ? {ctl.emit_idx[1], ~ctl.emit_idx[1] & ctl.emit_idx[0],
                ctl.emit_idx[1] & ctl.emit_idx[0]}
             : ctl.emit_idx;
    assign off_x = k[2] ? offset_b_reg : offset_a_reg;
    assign off_y = k[2] ? offset_a_reg : offset_b_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            active_reg <= active_next;
            if (ctl.emit)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.capture)
        begin
            mid_x_reg <= center_x;
            mid_y_reg <= center_y;
            dx_reg    <= abs_dx;
            dy_reg    <= abs_dy;
        end
        if (ctl.sq_first)
            sq_reg <= prod;
        if (ctl.sq_second)
        begin
            rad_reg  <= RAD_W'(dist_sq);
            rem_reg  <= '0;
            root_reg <= '0;
        end
        if (ctl.root_iter)
        begin
            rad_reg <= {rad_reg[RAD_W-3:0], 2'b00};
            if (fits)
            begin
                rem_reg  <= rem_diff[R_W+1:0];
                root_reg <= {root_reg[R_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg  <= rem_sh[R_W+1:0];
                root_reg <= {root_reg[R_W-2:0], 1'b0};
            end
        end
        if (ctl.load_circle)
        begin
            offset_a_reg <= '0;
            offset_b_reg <= root_reg;
            decision_reg <= D_W'(1) - {3'b000, root_reg};
            step_a_reg   <= '0;
            step_b_reg   <= D_W'(0) - {2'b00, root_reg, 1'b0};
        end
        if (ctl.step)
        begin
            offset_a_reg <= offset_a_next;
            offset_b_reg <= offset_b_next;
            decision_reg <= decision_next;
            step_a_reg   <= step_a_next;
            step_b_reg   <= step_b_next;
        end
        if (ctl.emit)
        begin
            pixel_x_reg  <= pix_sum(32'(mid_x_reg), 32'(off_x), k[0]);
            pixel_y_reg  <= pix_sum(32'(mid_y_reg), 32'(off_y), k[1]);
            run_end_reg  <= ctl.emit_last;
            done_res_reg <= !active_reg;
        end
    end

    assign status.active   = active_reg;
    assign status.out_free = !out_valid_reg || out_ready;

    assign out_valid = out_valid_reg;
    assign pixel_x   = pixel_x_reg;
    assign pixel_y   = pixel_y_reg;
    assign run_end   = run_end_reg;
    assign done_res  = done_res_reg;

endmodule

// File: rtl/midpoint_circle_rasterizer_core.sv
// top level of the midpoint circle rasteriser
`timescale 1ns / 1ps

// Takes one request at a time. A start request (cmd 0) squares the centre-to-edge
// distances on one shared multiplier, then finds the radius with a restoring square
// root that settles one result bit a cycle, loads the circle and sends the four axis
// pixels, waiting longer when the output stalls. A step request (cmd 1) updates the
// decision variable and sends eight pixels, one per cycle through the output register
// while the output is not stalled. A step with no circle in progress is taken and
// produces nothing. run_end marks the last pixel of a request, done_res says the
// octant is finished.

module midpoint_circle_rasterizer_core
    import mcr_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic                    cmd,
    input  logic [COORD_BITS-1:0]   center_x,
    input  logic [COORD_BITS-1:0]   center_y,
    input  logic [COORD_BITS-1:0]   edge_x,
    input  logic [COORD_BITS-1:0]   edge_y,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic signed [PIX_W-1:0] pixel_x,
    output logic signed [PIX_W-1:0] pixel_y,
    output logic                    run_end,
    output logic                    done_res
);

    mcr_ctl_t    ctl;
    mcr_status_t status;

    mcr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .cmd      (cmd),
        .status   (status),
        .ctl      (ctl)
    );

    mcr_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .status    (status),
        .center_x  (center_x),
        .center_y  (center_y),
        .edge_x    (edge_x),
        .edge_y    (edge_y),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .pixel_x   (pixel_x),
        .pixel_y   (pixel_y),
        .run_end   (run_end),
        .done_res  (done_res)
    );

endmodule

// File: test/midpoint_circle_rasterizer_core_tb.sv
// self-checking testbench for the midpoint circle rasteriser core
`timescale 1ns / 1ps

module midpoint_circle_rasterizer_core_tb;
    import mcr_pkg::*;

    localparam int MAX_COORD   = (1 << COORD_BITS) - 1;
    localparam int CYCLE_LIMIT = 200000;
    localparam int SETTLE      = 40;

    typedef struct packed {
        logic [PIX_W-1:0] px;
        logic [PIX_W-1:0] py;
        logic             last;
        logic             done;
    } pixel_t;

    logic                    clk = 1'b0;
    logic                    rst_n;
    logic                    in_valid;
    logic                    in_ready;
    logic                    cmd;
    logic [COORD_BITS-1:0]   center_x;
    logic [COORD_BITS-1:0]   center_y;
    logic [COORD_BITS-1:0]   edge_x;
    logic [COORD_BITS-1:0]   edge_y;
    logic                    out_valid;
    logic                    out_ready;
    logic signed [PIX_W-1:0] pixel_x;
    logic signed [PIX_W-1:0] pixel_y;
    logic                    run_end;
    logic                    done_res;

    // circle state of the predictor
    int   circ_cx;
    int   circ_cy;
    int   circ_x;
    int   circ_y;
    int   circ_d;
    int   circ_ddx;
    int   circ_ddy;
    logic circ_active;

    pixel_t pixel_q[$];

    int send_idle_pct;
    int recv_idle_pct;
    int cycles;
    int mismatches;
    int pixels_seen;
    int starts_sent;
    int steps_drawn;
    int steps_ignored;
    int octants_closed;

    midpoint_circle_rasterizer_core i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .cmd       (cmd),
        .center_x  (center_x),
        .center_y  (center_y),
        .edge_x    (edge_x),
        .edge_y    (edge_y),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .pixel_x   (pixel_x),
        .pixel_y   (pixel_y),
        .run_end   (run_end),
        .done_res  (done_res)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d pixels outstanding", cycles,
                     pixel_q.size());
            $display("Test completed with failures");
            $finish;
        end
    end

    always @(negedge clk)
        out_ready <= ($urandom_range(99) >= recv_idle_pct);

    // radius as floored square root, one result bit at a time from the top
    function automatic int radius_of(input int unsigned sq);
        int unsigned r;
        int unsigned trial;
        int          b;
        r = 0;
        for (b = 12; b >= 0; b--)
        begin
            trial = r | (32'd1 << b);
            if (trial * trial <= sq)
                r = trial;
        end
        return r;
    endfunction

    task automatic push_pixel(input int x, input int y, input logic last, input logic done);
        pixel_t p;
        p.px   = PIX_W'(x);
        p.py   = PIX_W'(y);
        p.last = last;
        p.done = done;
        pixel_q.push_back(p);
    endtask

    // expected pixels for one accepted request
    task automatic predict_request(input logic c, input int cx, input int cy,
                                   input int ex, input int ey);
        int   dx;
        int   dy;
        int   r;
        logic done;
        if (c == CMD_START)
        begin
            dx = (cx >= ex) ? cx - ex : ex - cx;
            dy = (cy >= ey) ? cy - ey : ey - cy;
            r = radius_of(dx * dx + dy * dy);
            circ_cx = cx;
            circ_cy = cy;
            circ_x = 0;
            circ_y = r;
            circ_d = 1 - r;
            circ_ddx = 0;
            circ_ddy = -2 * r;
            done = (r == 0);
            circ_active = !done;
            starts_sent++;
            if (done)
                octants_closed++;
            push_pixel(cx, cy + r, 1'b0, done);
            push_pixel(cx, cy - r, 1'b0, done);
            push_pixel(cx + r, cy, 1'b0, done);
            push_pixel(cx - r, cy, 1'b1, done);
        end
        else if (!circ_active || !(circ_x < circ_y))
        begin
            steps_ignored++;
        end
        else
        begin
            if (circ_d >= 0)
            begin
                circ_y -= 1;
                circ_ddy += 2;
                circ_d += circ_ddy;
            end
            circ_x += 1;
            circ_ddx += 2;
            circ_d += circ_ddx + 1;
            done = !(circ_x < circ_y);
            if (done)
            begin
                circ_active = 1'b0;
                octants_closed++;
            end
            steps_drawn++;
            push_pixel(circ_cx + circ_x, circ_cy + circ_y, 1'b0, done);
            push_pixel(circ_cx - circ_x, circ_cy + circ_y, 1'b0, done);
            push_pixel(circ_cx + circ_x, circ_cy - circ_y, 1'b0, done);
            push_pixel(circ_cx - circ_x, circ_cy - circ_y, 1'b0, done);
            push_pixel(circ_cx + circ_y, circ_cy + circ_x, 1'b0, done);
            push_pixel(circ_cx - circ_y, circ_cy + circ_x, 1'b0, done);
            push_pixel(circ_cx + circ_y, circ_cy - circ_x, 1'b0, done);
            push_pixel(circ_cx - circ_y, circ_cy - circ_x, 1'b1, done);
        end
    endtask

    task automatic send_request(input logic c, input int cx, input int cy,
                                input int ex, input int ey);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        cmd      <= c;
        center_x <= COORD_BITS'(cx);
        center_y <= COORD_BITS'(cy);
        edge_x   <= COORD_BITS'(ex);
        edge_y   <= COORD_BITS'(ey);
        do
            @(posedge clk);
        while (!in_ready);
        predict_request(c, cx, cy, ex, ey);
    endtask

    // step fields are don't-care, so they carry noise
    task automatic send_step();
        send_request(CMD_STEP, $urandom_range(MAX_COORD), $urandom_range(MAX_COORD),
                     $urandom_range(MAX_COORD), $urandom_range(MAX_COORD));
    endtask

    always @(posedge clk)
    begin
        pixel_t want;
        if (rst_n && out_valid && out_ready)
        begin
            pixels_seen++;
            if (pixel_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected pixel (%0d, %0d) run_end %b done %b",
                             pixel_x, pixel_y, run_end, done_res);
            end
            else
            begin
                want = pixel_q.pop_front();
                if (pixel_x !== want.px || pixel_y !== want.py
                    || run_end !== want.last || done_res !== want.done)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"pixel mismatch: expected (%0d, %0d) run_end %b done %b,",
                                  " got (%0d, %0d) run_end %b done %b"},
                                 $signed(want.px), $signed(want.py), want.last, want.done,
                                 pixel_x, pixel_y, run_end, done_res);
                end
            end
        end
    end

    task automatic test_step_without_circle();
        send_step();
        send_step();
    endtask

    task automatic test_zero_radius();
        send_request(CMD_START, 1024, 1024, 1024, 1024);
        send_step();
    endtask

    // largest radii, pixels wrapping below zero and past the canvas
    task automatic test_canvas_extremes();
        send_request(CMD_START, 0, 0, MAX_COORD, MAX_COORD);
        send_step();
        send_request(CMD_START, MAX_COORD, MAX_COORD, 0, 0);
        send_step();
        send_request(CMD_START, 0, MAX_COORD, MAX_COORD, 0);
        send_step();
    endtask

    task automatic test_full_octant();
        send_request(CMD_START, 5, 2040, 8, 2044);
        while (circ_active)
            send_step();
        send_step();
    endtask

    task automatic test_restart();
        send_request(CMD_START, 700, 300, 706, 308);
        send_step();
        send_step();
        send_request(CMD_START, 1400, 1900, 1401, 1900);
        send_step();
        send_step();
    endtask

    function automatic int near_coord(input int base, input int span);
        int v;
        v = base + $urandom_range(2 * span) - span;
        if (v < 0)
            v = 0;
        if (v > MAX_COORD)
            v = MAX_COORD;
        return v;
    endfunction

    // mostly whole circles with random content, some cut short, plus stray requests
    task automatic test_random_circles(input int n, input int s_pct, input int r_pct);
        int served;
        int cx;
        int cy;
        int span;
        int pick;
        int limit;
        int k;
        send_idle_pct = s_pct;
        recv_idle_pct = r_pct;
        served = 0;
        while (served < n)
        begin
            if ($urandom_range(99) < 85)
            begin
                cx = $urandom_range(MAX_COORD);
                cy = $urandom_range(MAX_COORD);
                pick = $urandom_range(99);
                span = (pick < 70) ? 12 : 200;
                if (pick < 90)
                    send_request(CMD_START, cx, cy, near_coord(cx, span), near_coord(cy, span));
                else
                    send_request(CMD_START, cx, cy, $urandom_range(MAX_COORD),
                                 $urandom_range(MAX_COORD));
                served++;
                limit = ($urandom_range(99) < 25) ? $urandom_range(4) : 30;
                k = 0;
                while (circ_active && k < limit)
                begin
                    send_step();
                    served++;
                    k++;
                end
                if ($urandom_range(1))
                    send_step();
            end
            else if ($urandom_range(1))
            begin
                if (circ_active)
                    served++;
                send_step();
            end
            else
            begin
                send_request(CMD_START, $urandom_range(MAX_COORD), $urandom_range(MAX_COORD),
                             $urandom_range(MAX_COORD), $urandom_range(MAX_COORD));
                served++;
            end
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        cmd = CMD_START;
        center_x = '0;
        center_y = '0;
        edge_x = '0;
        edge_y = '0;
        out_ready = 1'b0;
        cycles = 0;
        mismatches = 0;
        pixels_seen = 0;
        starts_sent = 0;
        steps_drawn = 0;
        steps_ignored = 0;
        octants_closed = 0;
        circ_cx = 0;
        circ_cy = 0;
        circ_x = 0;
        circ_y = 0;
        circ_d = 0;
        circ_ddx = 0;
        circ_ddy = 0;
        circ_active = 1'b0;
        send_idle_pct = 21;
        recv_idle_pct = 73;
        repeat (2) @(negedge clk);
        rst_n = 1'b1;

        test_step_without_circle();
        test_zero_radius();
        test_canvas_extremes();
        test_full_octant();
        test_restart();
        test_random_circles(30, 21, 73);
        test_random_circles(30, 73, 21);
        test_random_circles(30, 0, 0);

        @(negedge clk);
        in_valid <= 1'b0;
        while (pixel_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);

        $display("%0d circles started, %0d steps drawn, %0d idle steps, %0d octants closed",
                 starts_sent, steps_drawn, steps_ignored, octants_closed);
        $display("%0d pixels checked in %0d cycles, %0d mismatches",
                 pixels_seen, cycles, mismatches);
        if (mismatches == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// File: midpoint_circle_rasterizer_core.f
rtl/mcr_pkg.sv
rtl/mcr_ctrl.sv
rtl/mcr_datapath.sv
rtl/midpoint_circle_rasterizer_core.sv
test/midpoint_circle_rasterizer_core_tb.sv
